// File: hw/rtl/mpu_pkg.sv
// types and constants shared by the masked pixel unpacker
package mpu_pkg;

	localparam int NUM_CH    = 4;
	localparam int MASK_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int RECIP_W   = 33;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LUMINANCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RB    = 3'd7;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_WIDE,
		KIND_NARROW
	} chan_kind_t;

	typedef struct packed {
		chan_kind_t         kind;
		logic [4:0]         shift;
		logic [2:0]         lsh;
		logic [7:0]         amask;
		logic [RECIP_W-1:0] recip;
		logic [MASK_W-1:0]  mask;
	} chan_prm_t;

	typedef struct packed {
		chan_prm_t [NUM_CH-1:0] ch;
		logic                   lum;
		logic                   swap;
	} setup_t;

	typedef struct packed {
		logic [MASK_W-1:0] word;
		logic              last;
	} word_t;

endpackage

// File: hw/rtl/masked_pixel_unpack_rgba8.sv
// top level of the bit-mask pixel unpacker to rgba8
//
//  channel  handshake             payload
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in_valid/in_ready     pixel_byte, last_byte
//  out      out_valid/out_ready   red, green, blue, alpha, last_pixel
//
// one byte beat per cycle is taken while in_ready is high; a pixel leaves via the word queue and the
// stage 1, stage 2 and output registers; the conversion pipe takes one pixel per cycle unless the out
// side stalls, so with one byte per pixel both sides run at one a cycle; after reset and every cfg beat
// in_ready stays low until setup is done (for each of four channels a mask scan, a class step, a
// divide if narrow and a next step); a stalled out side fills the word queue, then in_ready drops
module masked_pixel_unpack_rgba8 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpu_pkg::MASK_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    pixel_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          last_pixel
);
	import mpu_pkg::*;

	setup_t     prm;
	logic [2:0] bpp;
	logic       setup_done;
	logic       push_valid, push_ready;
	word_t      push_data;
	logic       pop_valid, pop_ready;
	word_t      pop_data;

	mpu_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bpp       (bpp),
		.prm       (prm),
		.done      (setup_done)
	);

	mpu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_byte (pixel_byte),
		.last_byte  (last_byte),
		.bpp        (bpp),
		.go         (setup_done),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mpu_queue #(
		.WIDTH ($bits(word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.prm        (prm),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

endmodule

// File: hw/rtl/mpu_setup.sv
// configuration registers and serial derivation of per-channel shift, length and reciprocal
module mpu_setup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mpu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpu_pkg::MASK_W-1:0]      cfg_data,
	output logic [2:0]                      bpp,
	output mpu_pkg::setup_t                 prm,
	output logic                            done
);
	import mpu_pkg::*;

	typedef enum logic [2:0] {
		ST_SCAN,
		ST_CALC,
		ST_DIV,
		ST_NEXT,
		ST_DONE
	} st_t;

	st_t                    st_q;
	logic [MASK_W-1:0]      red_mask_q, green_mask_q, blue_mask_q, alpha_mask_q;
	logic                   alpha_en_q, lum_q, swap_q;
	logic [2:0]             bpp_q;
	logic [1:0]             ch_q;
	logic [4:0]             cnt_q;
	logic [5:0]             len_q;
	logic [4:0]             sh_q;
	logic                   found_q;
	logic [15:0]            d_q;
	logic [15:0]            rem_q;
	logic [31:0]            quo_q;
	chan_prm_t [NUM_CH-1:0] chp_q;

	logic [MASK_W-1:0]      mask_sel;
	chan_kind_t             kind_d;
	logic [4:0]             shift_d;
	logic [2:0]             lsh_d;
	logic [MASK_W-1:0]      aligned_d;
	logic [5:0]             wide_shift;
	logic [16:0]            trial;
	logic [16:0]            diff;
	logic                   qbit_d;
	logic [15:0]            rem_d;

	always_comb begin
		case (ch_q)
			CH_RED:   mask_sel = red_mask_q;
			CH_GREEN: mask_sel = green_mask_q;
			CH_BLUE:  mask_sel = blue_mask_q;
			CH_ALPHA: mask_sel = alpha_en_q ? alpha_mask_q : '0;
			default:  mask_sel = '0;
		endcase
	end

	// channel class from the scanned length and lowest set bit
	always_comb begin
		wide_shift = {1'b0, sh_q} + len_q - 6'd8;
		lsh_d      = 3'(4'd8 - len_q[3:0]);
		aligned_d  = (mask_sel >> sh_q) << lsh_d;
		shift_d    = sh_q;
		if (len_q == 6'd0) begin
			kind_d = KIND_ZERO;
		end else if (len_q > 6'd8) begin
			kind_d  = KIND_WIDE;
			shift_d = wide_shift[4:0];
		end else if (aligned_d[31:16] != 16'd0 || aligned_d == '0) begin
			kind_d = KIND_ZERO;
		end else begin
			kind_d = KIND_NARROW;
		end
	end

	// restoring divide of all-ones by the aligned mask, one quotient bit a cycle
	always_comb begin
		trial  = {rem_q, 1'b1};
		diff   = trial - {1'b0, d_q};
		qbit_d = trial >= {1'b0, d_q};
		rem_d  = qbit_d ? diff[15:0] : trial[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= 32'h00FF_0000;
			green_mask_q <= 32'h0000_FF00;
			blue_mask_q  <= 32'h0000_00FF;
			alpha_mask_q <= 32'hFF00_0000;
			alpha_en_q   <= 1'b0;
			bpp_q        <= 3'd4;
			lum_q        <= 1'b0;
			swap_q       <= 1'b0;
			st_q         <= ST_SCAN;
			ch_q         <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			sh_q         <= '0;
			found_q      <= 1'b0;
			d_q          <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			chp_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RED_MASK:   red_mask_q   <= cfg_data;
				CFG_GREEN_MASK: green_mask_q <= cfg_data;
				CFG_BLUE_MASK:  blue_mask_q  <= cfg_data;
				CFG_ALPHA_MASK: alpha_mask_q <= cfg_data;
				CFG_ALPHA_EN:   alpha_en_q   <= cfg_data[0];
				CFG_BPP:        bpp_q        <= cfg_data[2:0];
				CFG_LUMINANCE:  lum_q        <= cfg_data[0];
				CFG_SWAP_RB:    swap_q       <= cfg_data[0];
				default:        ;
			endcase
			st_q    <= ST_SCAN;
			ch_q    <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (st_q)
				ST_SCAN: begin
					if (mask_sel[cnt_q]) begin
						len_q <= len_q + 6'd1;
						if (!found_q) begin
							sh_q    <= cnt_q;
							found_q <= 1'b1;
						end
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					chp_q[ch_q].kind  <= kind_d;
					chp_q[ch_q].shift <= shift_d;
					chp_q[ch_q].lsh   <= lsh_d;
					chp_q[ch_q].amask <= aligned_d[7:0];
					chp_q[ch_q].mask  <= mask_sel;
					chp_q[ch_q].recip <= '0;
					d_q   <= aligned_d[15:0];
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					st_q  <= (kind_d == KIND_NARROW) ? ST_DIV : ST_NEXT;
				end
				ST_DIV: begin
					rem_q <= rem_d;
					quo_q <= {quo_q[30:0], qbit_d};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						chp_q[ch_q].recip <= {1'b0, quo_q[30:0], qbit_d} + 33'd1;
						st_q              <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					len_q   <= '0;
					found_q <= 1'b0;
					cnt_q   <= '0;
					if (ch_q == CH_ALPHA) begin
						st_q <= ST_DONE;
					end else begin
						ch_q <= ch_q + 2'd1;
						st_q <= ST_SCAN;
					end
				end
				ST_DONE: ;
				default: st_q <= ST_DONE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign bpp       = bpp_q;
	assign done      = (st_q == ST_DONE);
	assign prm       = '{ch: chp_q, lum: lum_q, swap: swap_q};

endmodule

// File: hw/rtl/mpu_front.sv
// byte gathering into little-endian pixel words
module mpu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      pixel_byte,
	input  logic            last_byte,
	input  logic [2:0]      bpp,
	input  logic            go,
	output logic            push_valid,
	input  logic            push_ready,
	output mpu_pkg::word_t  push_data
);
	import mpu_pkg::*;

	logic [1:0]        pos_q;
	logic [23:0]       partial_q;
	logic [2:0]        n_d;
	logic              wait_more;
	logic              accept;
	logic [MASK_W-1:0] word_d;

	always_comb begin
		if (bpp == 3'd0) begin
			n_d = 3'd1;
		end else if (bpp > 3'd4) begin
			n_d = 3'd4;
		end else begin
			n_d = bpp;
		end
	end

	assign in_ready   = go && push_ready;
	assign accept     = in_valid && in_ready;
	assign wait_more  = ({1'b0, pos_q} + 3'd1 < n_d) && !last_byte;
	assign word_d     = {8'd0, partial_q} | (32'(pixel_byte) << {pos_q, 3'b000});
	assign push_valid = accept && !wait_more;
	assign push_data  = '{word: word_d, last: last_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			partial_q <= '0;
		end else if (accept) begin
			if (wait_more) begin
				pos_q     <= pos_q + 2'd1;
				partial_q <= word_d[23:0];
			end else begin
				pos_q     <= '0;
				partial_q <= '0;
			end
		end
	end

endmodule

// File: hw/rtl/mpu_queue.sv
// small word queue between byte gathering and conversion
module mpu_queue #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/mpu_back.sv
// channel extraction, rescale by reciprocal multiply and output register
module mpu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mpu_pkg::setup_t prm,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  mpu_pkg::word_t  pop_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic [7:0]      alpha,
	output logic            last_pixel
);
	import mpu_pkg::*;

	logic                      adv;
	logic                      v_s1, v_s2, out_v_q;
	logic                      last_s1, last_s2, last_q;
	logic [NUM_CH-1:0][7:0]    val_d, val_s1, res_d, res_s2;
	logic [NUM_CH-1:0]         nar_s1;
	logic [NUM_CH-1:0][31:0]   wide_w, nar_w;
	logic [NUM_CH-1:0][15:0]   x_w;
	logic [NUM_CH-1:0][48:0]   prod_w;
	logic [7:0]                r_d, g_d, b_d;

	assign adv       = !out_v_q || out_ready;
	assign pop_ready = adv;

	// stage 1: pick the channel bits out of the word
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			wide_w[c] = (pop_data.word & prm.ch[c].mask) >> prm.ch[c].shift;
			nar_w[c]  = pop_data.word >> prm.ch[c].shift;
			case (prm.ch[c].kind)
				KIND_WIDE:   val_d[c] = wide_w[c][7:0];
				KIND_NARROW: val_d[c] = 8'(nar_w[c][7:0] << prm.ch[c].lsh) & prm.ch[c].amask;
				default:     val_d[c] = 8'd0;
			endcase
		end
	end

	// stage 2: for narrow channels col * 255 / aligned mask as a multiply by the stored reciprocal, others pass through
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			x_w[c]    = {val_s1[c], 8'd0} - {8'd0, val_s1[c]};
			prod_w[c] = 49'(x_w[c]) * 49'(prm.ch[c].recip);
			res_d[c]  = nar_s1[c] ? prod_w[c][39:32] : val_s1[c];
		end
	end

	always_comb begin
		r_d = res_s2[CH_RED];
		g_d = res_s2[CH_GREEN];
		b_d = res_s2[CH_BLUE];
		if (prm.lum) begin
			g_d = res_s2[CH_RED];
			b_d = res_s2[CH_RED];
		end else if (prm.swap) begin
			r_d = res_s2[CH_BLUE];
			b_d = res_s2[CH_RED];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop_valid;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1  <= val_d;
			last_s1 <= pop_data.last;
			for (int c = 0; c < NUM_CH; c++) begin
				nar_s1[c] <= (prm.ch[c].kind == KIND_NARROW);
			end
			res_s2  <= res_d;
			last_s2 <= last_s1;
			red     <= r_d;
			green   <= g_d;
			blue    <= b_d;
			alpha   <= res_s2[CH_ALPHA];
			last_q  <= last_s2;
		end
	end

	assign out_valid  = out_v_q;
	assign last_pixel = last_q;

endmodule

// File: verif/masked_pixel_unpack_rgba8_test.sv
// testbench for the bit-mask pixel unpacker: directed and random byte streams checked against a predictor
`timescale 1ns / 100ps

module masked_pixel_unpack_rgba8_test;
	import mpu_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 12;
	localparam int RANDOM_BYTES = 1950;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} rgba_pixel_t;

	class unpack_scoreboard;
		logic [31:0]  chan_mask [NUM_CH];
		bit           alpha_on;
		bit           lum_on;
		bit           swap_on;
		logic [2:0]   px_bytes;
		int           gathered;
		logic [23:0]  partial;
		rgba_pixel_t  pending_pixels [$];
		int           mismatches;

		function new();
			chan_mask[CH_RED]   = 32'h00ff0000;
			chan_mask[CH_GREEN] = 32'h0000ff00;
			chan_mask[CH_BLUE]  = 32'h000000ff;
			chan_mask[CH_ALPHA] = 32'hff000000;
			alpha_on   = 0;
			lum_on     = 0;
			swap_on    = 0;
			px_bytes   = 3'd4;
			gathered   = 0;
			partial    = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_RED_MASK:   chan_mask[CH_RED] = data;
				CFG_GREEN_MASK: chan_mask[CH_GREEN] = data;
				CFG_BLUE_MASK:  chan_mask[CH_BLUE] = data;
				CFG_ALPHA_MASK: chan_mask[CH_ALPHA] = data;
				CFG_ALPHA_EN:   alpha_on = data[0];
				CFG_BPP:        px_bytes = data[2:0];
				CFG_LUMINANCE:  lum_on = data[0];
				CFG_SWAP_RB:    swap_on = data[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] chan_value(logic [31:0] word, logic [31:0] mask);
			int          sh;
			int          len;
			logic [31:0] aligned;
			logic [31:0] col;
			if (mask == 0)
				return 8'd0;
			sh = 0;
			while (!mask[sh])
				sh++;
			len = $countones(mask);
			if (len > 8)
				return 8'((((word & mask) >> sh) >> (len - 8)) & 32'hff);
			aligned = (mask >> sh) << (8 - len);
			col = ((word >> sh) << (8 - len)) & aligned & 32'hff;
			if (aligned == 0)
				return 8'd0;
			return 8'(((col * 32'hff) / aligned) & 32'hff);
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			int          n;
			logic [31:0] word;
			rgba_pixel_t px;
			logic [7:0]  t;
			n = px_bytes;
			if (n == 0)
				n = 1;
			if (n > 4)
				n = 4;
			word = {8'h00, partial} | (32'(b) << (8 * gathered));
			if (gathered + 1 < n && !last) begin
				partial = word[23:0];
				gathered = gathered + 1;
				return;
			end
			gathered = 0;
			partial = '0;
			px.red   = chan_value(word, chan_mask[CH_RED]);
			px.green = chan_value(word, chan_mask[CH_GREEN]);
			px.blue  = chan_value(word, chan_mask[CH_BLUE]);
			px.alpha = chan_value(word, alpha_on ? chan_mask[CH_ALPHA] : 32'h0);
			px.last  = last;
			if (lum_on) begin
				px.green = px.red;
				px.blue  = px.red;
			end else if (swap_on) begin
				t        = px.red;
				px.red   = px.blue;
				px.blue  = t;
			end
			pending_pixels.push_back(px);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
		endtask

		task check_pixel(rgba_pixel_t got);
			rgba_pixel_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with none pending");
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("red", got.red, want.red);
			compare_field("green", got.green, want.green);
			compare_field("blue", got.blue, want.blue);
			compare_field("alpha", got.alpha, want.alpha);
			compare_field("last_pixel", 8'(got.last), 8'(want.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MASK_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           pixel_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic                 last_pixel;

	unpack_scoreboard sb;
	bit calm = 0;
	int bytes_sent = 0;
	int pixels_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	masked_pixel_unpack_rgba8 uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_byte(pixel_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_pixel(last_pixel)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_pixel({red, green, blue, alpha, last_pixel});
			pixels_seen++;
			if (pixels_seen == 300 || pixels_seen == 1100)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 37);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		pixel_byte <= b;
		last_byte  <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_byte(b, l);
		bytes_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_mask(int nb);
		int          kind;
		int          sh;
		int          len;
		logic [63:0] ones;
		kind = $urandom_range(0, 9);
		case (kind)
			0: return 32'h0;
			1: return 32'hffffffff;
			2, 3: return $urandom;
			default: begin
				sh = $urandom_range(0, 8 * nb - 1);
				if ($urandom_range(0, 1))
					len = $urandom_range(1, (32 - sh < 8) ? 32 - sh : 8);
				else
					len = $urandom_range(1, 32 - sh);
				ones = (64'h1 << len) - 1;
				return 32'(ones << sh);
			end
		endcase
	endfunction

	task automatic random_config();
		logic [2:0] code;
		int         nb;
		if ($urandom_range(0, 9) < 8)
			code = 3'($urandom_range(1, 4));
		else
			code = 3'($urandom_range(0, 1) ? 0 : $urandom_range(5, 7));
		nb = (code == 0) ? 1 : (code > 4) ? 4 : code;
		write_reg(CFG_BPP, ($urandom & ~32'h7) | 32'(code));
		write_reg(CFG_RED_MASK, pick_mask(nb));
		write_reg(CFG_GREEN_MASK, pick_mask(nb));
		write_reg(CFG_BLUE_MASK, pick_mask(nb));
		write_reg(CFG_ALPHA_MASK, pick_mask(nb));
		write_reg(CFG_ALPHA_EN, ($urandom & ~32'h1) | 32'($urandom_range(0, 1)));
		write_reg(CFG_LUMINANCE, ($urandom & ~32'h1) | 32'($urandom_range(0, 3) == 0));
		write_reg(CFG_SWAP_RB, ($urandom & ~32'h1) | 32'($urandom_range(0, 1)));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int         phase;
		int         count;
		int         pick;
		logic [7:0] b;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, alpha disabled
		repeat (4) send_byte(8'h00, 1'b0);
		repeat (4) send_byte(8'hff, 1'b0);
		// short final pixel
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b1);
		// size shrinks while a word is half built
		send_byte(8'ha5, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'hc3, 1'b0);
		drain();
		write_reg(CFG_BPP, 32'd2);
		cfg_valid <= 1'b0;
		send_byte(8'h81, 1'b0);
		drain();

		// zero size, narrow masks, luminance over swap
		write_reg(CFG_BPP, 32'd0);
		write_reg(CFG_RED_MASK, 32'h00000007);
		write_reg(CFG_GREEN_MASK, 32'h00000018);
		write_reg(CFG_BLUE_MASK, 32'h00000001);
		write_reg(CFG_ALPHA_MASK, 32'h000000f0);
		write_reg(CFG_ALPHA_EN, 32'd1);
		write_reg(CFG_LUMINANCE, 32'd1);
		write_reg(CFG_SWAP_RB, 32'd1);
		cfg_valid <= 1'b0;
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5a, 1'b1);
		drain();

		// oversized size, scattered and full masks, swap alone
		write_reg(CFG_BPP, 32'd7);
		write_reg(CFG_RED_MASK, 32'h80000001);
		write_reg(CFG_GREEN_MASK, 32'h0f0f0f0f);
		write_reg(CFG_BLUE_MASK, 32'hffffffff);
		write_reg(CFG_ALPHA_MASK, 32'h0);
		write_reg(CFG_LUMINANCE, 32'd0);
		cfg_valid <= 1'b0;
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'hfe, 1'b0);
		repeat (4) send_byte(8'hff, 1'b0);
		drain();

		bytes_sent = 0;
		phase = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			random_config();
			calm = (phase == 2);
			count = $urandom_range(60, 250);
			repeat (count) begin
				pick = $urandom_range(0, 99);
				b = (pick < 15) ? 8'h00 : (pick < 30) ? 8'hff : 8'($urandom);
				send_byte(b, $urandom_range(0, 39) == 0);
			end
			drain();
			phase++;
		end
		calm = 0;

		while (sb.pending_pixels.size() != 0) begin
			sb.report_mismatch("pixel never arrived");
			void'(sb.pending_pixels.pop_front());
		end
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/mpu_pkg.sv
hw/rtl/mpu_setup.sv
hw/rtl/mpu_front.sv
hw/rtl/mpu_queue.sv
hw/rtl/mpu_back.sv
hw/rtl/masked_pixel_unpack_rgba8.sv
verif/masked_pixel_unpack_rgba8_test.sv
